// ----- src/pfwp_pkg.sv -----
// Package with the shared types and constants of the PLL frequency word programmer.
package pfwp_pkg;

  localparam int ACC_W     = 22;
  localparam int REM_W     = 16;
  localparam int NUM_CELLS = ACC_W;
  localparam int FREQ_W    = 12;
  localparam int STEP_W    = 14;
  localparam int REF_W     = 16;
  localparam int BAND_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CODE_W    = 3;
  localparam int VCO_W     = FREQ_W + 6;
  localparam int PFD_W     = STEP_W + 6;
  localparam int R_W       = 10;
  localparam int NINT_W    = 16;

  localparam logic [CFG_W-1:0]  REFERENCE_KHZ_RESET = 16'd10000;
  localparam logic [BAND_W-1:0] BAND_SELECT_RESET   = 8'd160;

  localparam logic [VCO_W-1:0] VCO_LOW_MHZ  = 18'd2200;
  localparam logic [VCO_W-1:0] VCO_HIGH_MHZ = 18'd4400;
  localparam logic [ACC_W-1:0] KHZ_PER_MHZ  = 22'd1000;

  localparam logic [31:0] R5_WORD = 32'h0058_0005;
  localparam logic [31:0] R4_BASE = 32'h0080_003C;
  localparam logic [31:0] R3_WORD = 32'h0084_8503;
  localparam logic [31:0] R2_BASE = 32'h6100_2042;
  localparam logic [31:0] R1_WORD = 32'h0100_8009;

  localparam logic REG_REFERENCE_KHZ = 1'b0;
  localparam logic REG_BAND_SELECT   = 1'b1;

  typedef enum logic [2:0] {
    WORD_R5,
    WORD_R4,
    WORD_R3,
    WORD_R2,
    WORD_R1,
    WORD_R0
  } word_sel_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [ACC_W-1:0] acc;
    logic [REM_W-1:0] dsr;
  } lane_t;

  typedef struct packed {
    logic              valid;
    logic              err;
    logic [CODE_W-1:0] code;
    lane_t             a;
    lane_t             b;
  } cell_t;

endpackage

// ----- src/pfwp_req_if.sv -----
// Request channel carrying the target frequency and the channel step.
interface pfwp_req_if;
  logic        valid;
  logic        ready;
  logic [11:0] freq_mhz;
  logic [13:0] resolution_khz;

  modport source (output valid, output freq_mhz, output resolution_khz, input ready);
  modport sink (input valid, input freq_mhz, input resolution_khz, output ready);
endinterface

// ----- src/pfwp_rsp_if.sv -----
// Result channel carrying one synthesizer register word per beat.
interface pfwp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last;
  logic        error;

  modport source (output valid, output word, output last, output error, input ready);
  modport sink (input valid, input word, input last, input error, output ready);
endinterface

// ----- src/pfwp_front.sv -----
// Entry logic: picks the output divider, forms the PFD and loads both divider lanes.
module pfwp_front (
  input  logic                       valid,
  input  logic [pfwp_pkg::FREQ_W-1:0] freq_mhz,
  input  logic [pfwp_pkg::STEP_W-1:0] resolution_khz,
  input  logic [pfwp_pkg::REF_W-1:0]  reference_khz,
  output pfwp_pkg::cell_t            q
);
  import pfwp_pkg::*;

  logic [CODE_W-1:0] code;
  logic [PFD_W-1:0]  pfd;

  always_comb begin
    logic [VCO_W-1:0] vco;
    code = '0;
    for (int c = 6; c >= 1; c--) begin
      vco = VCO_W'(freq_mhz) << c;
      if (vco > VCO_LOW_MHZ && vco < VCO_HIGH_MHZ) begin
        code = CODE_W'(c);
      end
    end
  end

  assign pfd = PFD_W'(resolution_khz) << code;

  always_comb begin
    q.valid = valid;
    q.code  = code;
    q.err   = (code == '0) || (resolution_khz == '0) || (pfd[PFD_W-1:REM_W] != '0);
    q.a.rem = '0;
    q.a.acc = ACC_W'(freq_mhz) * KHZ_PER_MHZ;
    q.a.dsr = REM_W'(resolution_khz);
    q.b.rem = '0;
    q.b.acc = ACC_W'(reference_khz);
    q.b.dsr = pfd[REM_W-1:0];
  end

endmodule

// ----- src/pfwp_div_cell.sv -----
// One divider cell: a restoring step on each lane, registered toward the next cell.
module pfwp_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  pfwp_pkg::cell_t d,
  output pfwp_pkg::cell_t q
);
  import pfwp_pkg::*;

  function automatic lane_t lane_step(lane_t l);
    logic [REM_W:0] trial;
    lane_t          n;
    trial = {l.rem, l.acc[ACC_W-1]};
    n = l;
    if (trial >= {1'b0, l.dsr}) begin
      n.rem = REM_W'(trial - {1'b0, l.dsr});
      n.acc = {l.acc[ACC_W-2:0], 1'b1};
    end else begin
      n.rem = trial[REM_W-1:0];
      n.acc = {l.acc[ACC_W-2:0], 1'b0};
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      q.err  <= d.err;
      q.code <= d.code;
      q.a    <= lane_step(d.a);
      q.b    <= lane_step(d.b);
    end
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
  end

endmodule

// ----- src/pfwp_sequencer.sv -----
// Word sequencer: checks the quotients and sends the six register words, R5 first, or one zero error beat.
module pfwp_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  pfwp_pkg::cell_t             d,
  input  logic [pfwp_pkg::BAND_W-1:0] band_select_divider,
  output logic                        take,
  pfwp_rsp_if.source                  rsp
);
  import pfwp_pkg::*;

  logic              busy;
  logic              err;
  logic [CODE_W-1:0] code;
  logic [R_W-1:0]    r;
  logic [NINT_W-1:0] nint;
  word_sel_t         idx;
  logic              last_beat;
  logic              load;

  assign last_beat = err || (idx == WORD_R0);
  assign take      = !busy || (rsp.ready && last_beat);
  assign load      = take && d.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= WORD_R5;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= WORD_R5;
    end else if (busy && rsp.ready) begin
      if (last_beat) begin
        busy <= 1'b0;
      end else begin
        idx <= word_sel_t'(idx + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      err  <= d.err || (d.b.acc == '0) || (d.b.acc[ACC_W-1:R_W] != '0)
              || (d.a.acc[ACC_W-1:NINT_W] != '0);
      code <= d.code;
      r    <= d.b.acc[R_W-1:0];
      nint <= d.a.acc[NINT_W-1:0];
    end
  end

  always_comb begin
    case (idx)
      WORD_R5: rsp.word = R5_WORD;
      WORD_R4: rsp.word = R4_BASE | {9'b0, code, band_select_divider, 12'b0};
      WORD_R3: rsp.word = R3_WORD;
      WORD_R2: rsp.word = R2_BASE | {8'b0, r, 14'b0};
      WORD_R1: rsp.word = R1_WORD;
      WORD_R0: rsp.word = {1'b0, nint, 15'b0};
      default: rsp.word = '0;
    endcase
    if (err) begin
      rsp.word = '0;
    end
  end

  assign rsp.valid = busy;
  assign rsp.last  = last_beat;
  assign rsp.error = err;

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.error |-> rsp.last && rsp.word == '0)
    else $error("error beat is not a lone zero word");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    busy && !rsp.ready |=> busy && $stable(idx))
    else $error("word index moved during a stall");

  a_sequence_continues: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && !rsp.last |=> rsp.valid && !rsp.error)
    else $error("word sequence broken before its last beat");

endmodule

// ----- src/pll_frequency_word_programmer_top.sv -----
// Top level of the PLL frequency word programmer.
//
//   channel  | direction | beat contents
//   ---------+-----------+------------------------------------------
//   req      | in        | freq_mhz[11:0], resolution_khz[13:0]
//   rsp      | out       | word[31:0], last, error
//   cfg      | in        | cfg_wr_en, cfg_index[0], cfg_wdata[15:0]
//
// A request passes a chain of 22 divider cells, one quotient bit per cell and cycle
// while the chain is not held, and the sequencer registers it from the last cell.
// The sequencer sends six words, one per cycle while rsp is ready; an error request
// gives one beat. The chain holds up to 22 requests.
// A stall on rsp freezes the sequencer and then the whole chain.
// Reset clears the valid bits and loads reference_khz 10000 and band select 160.
module pll_frequency_word_programmer_top (
  input  logic        clk,
  input  logic        rst,
  pfwp_req_if.sink    req,
  pfwp_rsp_if.source  rsp,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import pfwp_pkg::*;

  logic [REF_W-1:0]  reference_khz;
  logic [BAND_W-1:0] band_select_divider;
  cell_t             chain [0:NUM_CELLS];
  logic              take;
  logic              en;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_khz       <= REFERENCE_KHZ_RESET;
      band_select_divider <= BAND_SELECT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_REFERENCE_KHZ: reference_khz       <= cfg_wdata;
        REG_BAND_SELECT:   band_select_divider <= cfg_wdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  assign en        = !chain[NUM_CELLS].valid || take;
  assign req.ready = en;

  pfwp_front u_front (
    .valid          (req.valid),
    .freq_mhz       (req.freq_mhz),
    .resolution_khz (req.resolution_khz),
    .reference_khz  (reference_khz),
    .q              (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    pfwp_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  pfwp_sequencer u_seq (
    .clk                 (clk),
    .rst                 (rst),
    .d                   (chain[NUM_CELLS]),
    .band_select_divider (band_select_divider),
    .take                (take),
    .rsp                 (rsp)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the PLL frequency word programmer: random and directed requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfwp_pkg::*;

  localparam int unsigned VCO_MIN_MHZ   = 2200;
  localparam int unsigned VCO_MAX_MHZ   = 4400;
  localparam int unsigned PFD_MAX_KHZ   = 65535;
  localparam int unsigned R_MAX         = 1023;
  localparam int unsigned NINT_MAX      = 65535;
  localparam logic [31:0] R5_PATTERN    = 32'h0058_0000;
  localparam logic [31:0] R4_PATTERN    = 32'h0080_0038;
  localparam logic [31:0] R3_PATTERN    = 32'h0084_8000;
  localparam logic [31:0] R2_PATTERN    = 32'h6100_2040;
  localparam logic [31:0] R1_PATTERN    = 32'h0100_8000;
  localparam int unsigned R3_CLK_DIV    = 160;
  localparam int unsigned SHOWN_ERRORS  = 10;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        error;
  } reg_beat_t;

  class pll_word_scoreboard;
    reg_beat_t   pending_words[$];
    logic [15:0] ref_khz;
    logic [7:0]  band_div;
    int          fail_count;
    int          beat_count;

    function new();
      ref_khz    = 16'd10000;
      band_div   = 8'd160;
      fail_count = 0;
      beat_count = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == REG_REFERENCE_KHZ) ref_khz = data;
      else band_div = data[7:0];
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction

    // Works out the register words that one request produces.
    function void note_request(logic [11:0] freq, logic [13:0] step);
      int unsigned code, div, vco, pfd, r, nint;
      bit          bad;
      reg_beat_t   b;
      code = 0;
      div  = 0;
      pfd  = 0;
      r    = 0;
      nint = 0;
      for (int c = 1; c <= 6; c++) begin
        vco = 32'(freq) << c;
        if (div == 0 && vco > VCO_MIN_MHZ && vco < VCO_MAX_MHZ) begin
          code = c;
          div  = 1 << c;
        end
      end
      bad = (div == 0);
      if (!bad) begin
        pfd = 32'(step) * div;
        bad = (pfd == 0 || pfd > PFD_MAX_KHZ);
      end
      if (!bad) begin
        r   = 32'(ref_khz) / pfd;
        bad = (r == 0 || r > R_MAX);
      end
      if (!bad) begin
        nint = (32'(freq) * 1000 * div) / pfd;
        bad  = (nint > NINT_MAX);
      end
      if (bad) begin
        b = '{word: 32'd0, last: 1'b1, error: 1'b1};
        pending_words.push_back(b);
      end else begin
        pending_words.push_back('{R5_PATTERN | 32'd5, 1'b0, 1'b0});
        pending_words.push_back('{R4_PATTERN | (code << 20) | (32'(band_div) << 12) | 32'd4,
                                  1'b0, 1'b0});
        pending_words.push_back('{R3_PATTERN | (R3_CLK_DIV << 3) | 32'd3, 1'b0, 1'b0});
        pending_words.push_back('{R2_PATTERN | (r << 14) | 32'd2, 1'b0, 1'b0});
        pending_words.push_back('{R1_PATTERN | (32'd1 << 15) | (32'd1 << 3) | 32'd1,
                                  1'b0, 1'b0});
        pending_words.push_back('{nint << 15, 1'b1, 1'b0});
      end
    endfunction

    function void check_beat(logic [31:0] word, logic last, logic error);
      reg_beat_t exp_b;
      beat_count++;
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_ERRORS)
          $display("beat %0d unexpected: word %08h last %0b error %0b",
                   beat_count, word, last, error);
      end else begin
        exp_b = pending_words.pop_front();
        if (exp_b.word !== word || exp_b.last !== last || exp_b.error !== error) begin
          fail_count++;
          if (fail_count <= SHOWN_ERRORS)
            $display("beat %0d: expected %08h/%0b/%0b, got %08h/%0b/%0b",
                     beat_count, exp_b.word, exp_b.last, exp_b.error, word, last, error);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  int          idle_pct;
  int          stall_pct;

  pll_word_scoreboard sb;

  pfwp_req_if req_ch ();
  pfwp_rsp_if rsp_ch ();

  pll_frequency_word_programmer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_beat(rsp_ch.word, rsp_ch.last, rsp_ch.error);
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(input logic idx, input logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_request(input logic [11:0] freq, input logic [13:0] step,
                              input bit drain_first);
    if (drain_first || $urandom_range(99, 0) < idle_pct) begin
      req_ch.valid <= 1'b0;
      if (drain_first) begin
        do @(posedge clk); while (sb.outstanding() != 0);
      end else begin
        @(posedge clk);
      end
      while ($urandom_range(99, 0) < idle_pct) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.freq_mhz       <= freq;
    req_ch.resolution_khz <= step;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(freq, step);
  endtask

  // Most requests land in band with a step that keeps R and INT in their fields.
  function automatic void pick_request(output logic [11:0] freq, output logic [13:0] step);
    int unsigned code, d, vco_khz, pfd_lo, pfd_hi, step_lo, step_hi;
    if ($urandom_range(3, 0) == 0) begin
      freq = 12'($urandom_range(4095, 0));
      step = 14'($urandom_range(16383, 0));
    end else begin
      code    = $urandom_range(6, 1);
      d       = 1 << code;
      freq    = 12'($urandom_range((VCO_MAX_MHZ - 1) / d, VCO_MIN_MHZ / d + 1));
      vco_khz = 32'(freq) * 1000 * d;
      pfd_lo  = vco_khz / (NINT_MAX + 1) + 1;
      if (32'(sb.ref_khz) / (R_MAX + 1) + 1 > pfd_lo) pfd_lo = 32'(sb.ref_khz) / (R_MAX + 1) + 1;
      pfd_hi  = 32'(sb.ref_khz);
      step_lo = (pfd_lo + d - 1) / d;
      step_hi = pfd_hi / d;
      if (step_lo <= step_hi) step = 14'($urandom_range(step_hi, step_lo));
      else step = 14'($urandom_range(16383, 1));
    end
  endfunction

  task automatic run_random(input int count, input int idle, input int stall, input bit pressure);
    logic [11:0] f;
    logic [13:0] s;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      pick_request(f, s);
      send_request(f, s, pressure && (i % 4 == 0));
    end
    req_ch.valid <= 1'b0;
    wait_drained();
  endtask

  task automatic run_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(12'd0,    14'd100,   1'b0);
    send_request(12'd4095, 14'd100,   1'b0);
    send_request(12'd1100, 14'd100,   1'b0);
    send_request(12'd1101, 14'd100,   1'b0);
    send_request(12'd2199, 14'd100,   1'b0);
    send_request(12'd2200, 14'd100,   1'b0);
    send_request(12'd800,  14'd25,    1'b0);
    send_request(12'd300,  14'd10,    1'b0);
    send_request(12'd200,  14'd5,     1'b0);
    send_request(12'd100,  14'd2,     1'b0);
    send_request(12'd50,   14'd1,     1'b0);
    send_request(12'd35,   14'd1,     1'b0);
    send_request(12'd34,   14'd1,     1'b0);
    send_request(12'd1500, 14'd0,     1'b0);
    send_request(12'd100,  14'd16383, 1'b0);
    send_request(12'd1500, 14'd16383, 1'b0);
    send_request(12'd2000, 14'd10000, 1'b0);
    send_request(12'd2000, 14'd4,     1'b0);
    send_request(12'd2000, 14'd5,     1'b0);
    send_request(12'd1500, 14'd5000,  1'b0);
    send_request(12'd4095, 14'd16383, 1'b0);
    send_request(12'd0,    14'd0,     1'b0);
    req_ch.valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.freq_mhz       = '0;
    req_ch.resolution_khz = '0;
    cfg_wr_en             = 1'b0;
    cfg_index             = REG_REFERENCE_KHZ;
    cfg_wdata             = '0;
    idle_pct              = 0;
    stall_pct             = 0;
    sb                    = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_directed();

    write_reg(REG_REFERENCE_KHZ, 16'($urandom_range(65535, 1)));
    write_reg(REG_BAND_SELECT, 16'($urandom_range(255, 1)));
    run_random(40, 0, 0, 1'b0);

    write_reg(REG_REFERENCE_KHZ, 16'hFFFF);
    write_reg(REG_BAND_SELECT, 16'hFFFF);
    run_random(40, 64, 0, 1'b0);

    write_reg(REG_REFERENCE_KHZ, 16'd1);
    write_reg(REG_BAND_SELECT, 16'hFF01);
    run_random(6, 0, 0, 1'b0);

    write_reg(REG_REFERENCE_KHZ, 16'd10000);
    write_reg(REG_BAND_SELECT, 16'd160);
    run_random(30, 0, 64, 1'b0);

    write_reg(REG_REFERENCE_KHZ, 16'($urandom_range(65535, 1)));
    write_reg(REG_BAND_SELECT, 16'($urandom_range(255, 1)));
    run_random(32, 12, 12, 1'b1);

    repeat (30) @(posedge clk);
    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
